@@ rtl/core/serial_frame_receiver_defines.svh @@
// assertion macros for the serial frame receiver
// used by the top level only, relies on clk and rst_n in the including scope
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sfr_pkg.sv @@
// shared types and constants for the serial frame receiver
// no dependencies
package sfr_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 32;

    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] TYPE_MOTOR   = 8'h01;
    localparam logic [7:0] TYPE_GRIPPER = 8'h02;
    localparam logic [7:0] TYPE_LED     = 8'h03;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_LONG = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_BAD_CSUM = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_MOTOR_LEN   = 2'd0;
    localparam logic [1:0] REG_GRIPPER_LEN = 2'd1;
    localparam logic [1:0] REG_LED_LEN     = 2'd2;
    localparam logic [1:0] REG_TIMEOUT     = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    typedef struct packed {
        logic [5:0]  motor_len;
        logic [5:0]  gripper_len;
        logic [5:0]  led_len;
        logic [15:0] timeout;
    } cfg_t;

    // one finished frame handed from front to back
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_type;
        logic [7:0] length;
        logic       bank;
    } job_t;

    // back tells front that a payload bank is drained
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

@@ rtl/core/serial_frame_receiver.sv @@
// serial frame receiver: one input transaction per cycle unless full, which rises when
// the two-entry job queue is full or a payload byte targets a bank still draining.
// rejection or empty-frame results go through the job queue, then the output register;
// each payload byte goes from the registered ram read to the output register before the next read.
// async active-low reset clears parser, sequencer and config; the ram is not cleared.
// depends on sfr_pkg, sfr_job_fifo, sfr_payload_ram, sfr_front, sfr_back
`include "serial_frame_receiver_defines.svh"

module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [7:0]  frame_type,
    output logic [4:0]  byte_index,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        last
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    cfg_t           cfg_reg;
    logic           job_push;
    job_t           job;
    logic           job_full;
    logic           job_empty;
    logic           job_pop;
    job_t           head_job;
    release_t       bank_release;
    logic           ram_wr_en;
    logic [IDX_W:0] ram_wr_addr;
    logic [7:0]     ram_wr_data;
    logic           ram_rd_en;
    logic [IDX_W:0] ram_rd_addr;
    logic [7:0]     ram_rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_len   <= 6'd0;
            cfg_reg.gripper_len <= 6'd0;
            cfg_reg.led_len     <= 6'd0;
            cfg_reg.timeout     <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MOTOR_LEN:   cfg_reg.motor_len   <= cfg_data[5:0];
                REG_GRIPPER_LEN: cfg_reg.gripper_len <= cfg_data[5:0];
                REG_LED_LEN:     cfg_reg.led_len     <= cfg_data[5:0];
                REG_TIMEOUT:     cfg_reg.timeout     <= cfg_data;
                default:         cfg_reg.timeout     <= cfg_reg.timeout;
            endcase
        end
    end

    sfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .command      (command),
        .data_byte    (data_byte),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .job_push     (job_push),
        .job          (job),
        .job_full     (job_full),
        .bank_release (bank_release)
    );

    sfr_job_fifo u_job_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (job_push),
        .push_job   (job),
        .fifo_full  (job_full),
        .pop_en     (job_pop),
        .fifo_empty (job_empty),
        .head_job   (head_job)
    );

    sfr_payload_ram #(
        .ADDR_W (IDX_W + 1)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sfr_back #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (job_empty),
        .head_job     (head_job),
        .job_pop      (job_pop),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .bank_release (bank_release),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .frame_type   (frame_type),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .last         (last)
    );

    // checks
    `SFR_ASSERT_NOW(a_job_no_overflow, job_push, !job_full, "job pushed into full queue")
    `SFR_ASSERT_NOW(a_single_ends_run, !empty && !byte_valid, last, "dataless result without last")
    `SFR_ASSERT_NOW(a_reject_no_data, !empty && status != ST_OK, !byte_valid, "rejection carries data")
    `SFR_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "waiting result dropped without pop")

endmodule

@@ rtl/core/sfr_job_fifo.sv @@
// two-entry queue of finished frame jobs between front and back
// depends on sfr_pkg
module sfr_job_fifo
    import sfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_en,
    input  job_t push_job,
    output logic fifo_full,
    input  logic pop_en,
    output logic fifo_empty,
    output job_t head_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign fifo_full  = (count_reg == 2'd2);
    assign fifo_empty = (count_reg == 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push_en && !pop_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_en && !push_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/core/sfr_payload_ram.sv @@
// two-bank payload buffer, one write port and one registered read port
// depends on no package
module sfr_payload_ram #(
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/sfr_front.sv @@
// front part: frame parser that hunts, reads header, buffers payload and checks frames
// depends on sfr_pkg, drives the payload ram write port and the job queue
module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
    parameter int IDX_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             push,
    output logic             full,
    input  logic             command,
    input  logic [7:0]       data_byte,
    output logic             ram_wr_en,
    output logic [IDX_W:0]   ram_wr_addr,
    output logic [7:0]       ram_wr_data,
    output logic             job_push,
    output job_t             job,
    input  logic             job_full,
    input  release_t         bank_release
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       type_reg, type_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] rcvd_reg, rcvd_next;
    logic [7:0]       xor_reg, xor_next;
    logic [15:0]      ticks_reg, ticks_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;

    logic             accept;
    logic [7:0]       csum;
    logic [5:0]       need;
    logic             known;
    logic [2:0]       verdict;

    // stall when the job queue has no room or the target bank still drains
    assign full   = job_full || (phase_reg == PH_PAYLOAD && busy_reg[wbank_reg]);
    assign accept = push && !full;

    assign csum = xor_reg ^ data_byte;

    // required length by frame type
    always_comb
    begin
        need  = 6'd0;
        known = 1'b1;
        case (type_reg)
            TYPE_MOTOR:   need = cfg.motor_len;
            TYPE_GRIPPER: need = cfg.gripper_len;
            TYPE_LED:     need = cfg.led_len;
            default:      known = 1'b0;
        endcase
    end

    // frame verdict once the checksum byte is in
    always_comb
    begin
        if (csum != 8'd0)
        begin
            verdict = ST_BAD_CSUM;
        end
        else if (!known)
        begin
            verdict = ST_UNKNOWN;
        end
        else if (8'(need) != 8'(len_reg))
        begin
            verdict = ST_MISMATCH;
        end
        else
        begin
            verdict = ST_OK;
        end
    end

    assign ram_wr_data = data_byte;
    assign ram_wr_addr = {wbank_reg, rcvd_reg[IDX_W-1:0]};

    // parser next state
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        rcvd_next  = rcvd_reg;
        xor_next   = xor_reg;
        ticks_next = ticks_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        ram_wr_en  = 1'b0;
        job_push   = 1'b0;
        job.status     = ST_OK;
        job.frame_type = type_reg;
        job.length     = 8'(len_reg);
        job.bank       = wbank_reg;

        if (bank_release.valid)
        begin
            busy_next[bank_release.bank] = 1'b0;
        end

        if (accept && command)
        begin
            // timer tick, counts only while payload or checksum is awaited
            if (phase_reg == PH_PAYLOAD || phase_reg == PH_CHECK)
            begin
                ticks_next = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;
                if (ticks_next >= cfg.timeout)
                begin
                    job_push   = 1'b1;
                    job.status = ST_TIMEOUT;
                    phase_next = PH_HUNT;
                end
            end
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = data_byte;
                    xor_next   = data_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (data_byte > 8'(MAX_PAYLOAD))
                    begin
                        job_push   = 1'b1;
                        job.status = ST_TOO_LONG;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        len_next   = CNT_W'(data_byte);
                        xor_next   = xor_reg ^ data_byte;
                        rcvd_next  = '0;
                        ticks_next = 16'd0;
                        phase_next = (data_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    ram_wr_en = (32'(rcvd_reg) < MAX_PAYLOAD);
                    xor_next  = csum;
                    rcvd_next = rcvd_reg + CNT_W'(1);
                    if (rcvd_next >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    xor_next   = csum;
                    job_push   = 1'b1;
                    job.status = verdict;
                    phase_next = PH_HUNT;
                    // a nonempty accepted frame hands its bank to the back
                    if (verdict == ST_OK && len_reg != '0)
                    begin
                        busy_next[wbank_reg] = 1'b1;
                        wbank_next           = ~wbank_reg;
                    end
                end
                default:
                begin
                    phase_next = (data_byte == START_BYTE) ? PH_TYPE : PH_HUNT;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            type_reg  <= 8'd0;
            len_reg   <= '0;
            rcvd_reg  <= '0;
            xor_reg   <= 8'd0;
            ticks_reg <= 16'd0;
            wbank_reg <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            rcvd_reg  <= rcvd_next;
            xor_reg   <= xor_next;
            ticks_reg <= ticks_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

@@ rtl/core/sfr_back.sv @@
// back part: turns jobs into result transactions, reading payload from the ram
// depends on sfr_pkg, reads the job queue and the payload ram
module sfr_back
    import sfr_pkg::*;
#(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_empty,
    input  job_t           head_job,
    output logic           job_pop,
    output logic           ram_rd_en,
    output logic [IDX_W:0] ram_rd_addr,
    input  logic [7:0]     ram_rd_data,
    output release_t       bank_release,
    output logic           empty,
    input  logic           pop,
    output logic [2:0]     status,
    output logic [7:0]     frame_type,
    output logic [4:0]     byte_index,
    output logic [7:0]     payload_byte,
    output logic           byte_valid,
    output logic           last
);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DATA
    } back_state_t;

    back_state_t      state_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] len_reg;
    logic [7:0]       type_reg;
    logic             bank_reg;

    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [7:0]       type_out_reg;
    logic [4:0]       index_reg;
    logic [7:0]       byte_reg;
    logic             byte_valid_reg;
    logic             last_reg;

    logic             out_free;
    logic             run_job;
    logic             is_last;
    logic [7:0]       idx_wide;

    assign out_free = !out_valid_reg || pop;
    assign run_job  = (head_job.status == ST_OK) && (head_job.length != 8'd0);
    assign job_pop  = (state_reg == BK_IDLE) && !job_empty && out_free;
    assign is_last  = ({1'b0, idx_reg} + (CNT_W + 1)'(1)) == {1'b0, len_reg};
    assign idx_wide = 8'(idx_reg);

    assign ram_rd_en   = (state_reg == BK_RUN) && out_free;
    assign ram_rd_addr = {bank_reg, idx_reg[IDX_W-1:0]};

    assign bank_release.valid = (state_reg == BK_DATA) && is_last;
    assign bank_release.bank  = bank_reg;

    assign empty        = !out_valid_reg;
    assign status       = status_reg;
    assign frame_type   = type_out_reg;
    assign byte_index   = index_reg;
    assign payload_byte = byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign last         = last_reg;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            len_reg        <= '0;
            type_reg       <= 8'd0;
            bank_reg       <= 1'b0;
            status_reg     <= ST_OK;
            type_out_reg   <= 8'd0;
            index_reg      <= 5'd0;
            byte_reg       <= 8'd0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            // a pop empties the output register unless a single result reloads it
            if (pop && out_valid_reg && !(job_pop && !run_job))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                BK_IDLE:
                begin
                    if (job_pop)
                    begin
                        if (run_job)
                        begin
                            idx_reg   <= '0;
                            len_reg   <= head_job.length[CNT_W-1:0];
                            type_reg  <= head_job.frame_type;
                            bank_reg  <= head_job.bank;
                            state_reg <= BK_RUN;
                        end
                        else
                        begin
                            // single-transaction result: rejection or empty frame
                            out_valid_reg  <= 1'b1;
                            status_reg     <= head_job.status;
                            type_out_reg   <= head_job.frame_type;
                            index_reg      <= 5'd0;
                            byte_reg       <= 8'd0;
                            byte_valid_reg <= 1'b0;
                            last_reg       <= 1'b1;
                        end
                    end
                end
                BK_RUN:
                begin
                    if (out_free)
                    begin
                        state_reg <= BK_DATA;
                    end
                end
                BK_DATA:
                begin
                    // read data arrives, output register is free by construction
                    out_valid_reg  <= 1'b1;
                    status_reg     <= ST_OK;
                    type_out_reg   <= type_reg;
                    index_reg      <= idx_wide[4:0];
                    byte_reg       <= ram_rd_data;
                    byte_valid_reg <= 1'b1;
                    last_reg       <= is_last;
                    idx_reg        <= idx_reg + CNT_W'(1);
                    state_reg      <= is_last ? BK_IDLE : BK_RUN;
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

endmodule
